>>> rtl/core/pmicrs_pkg.sv
// Package for the display power chip register slave.
// Holds the function codes, register map constants and the bus command struct.
// No dependencies.
`default_nettype none

package pmicrs_pkg;

	localparam int REG_COUNT = 28;
	localparam int REG_IDX_W = $clog2(REG_COUNT);
	localparam int SETTLE_W  = 24;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t      TEMP_REG     = reg_idx_t'(0);
	localparam reg_idx_t      FAULT_REG_A  = reg_idx_t'(8'h1a);
	localparam reg_idx_t      FAULT_REG_B  = reg_idx_t'(8'h1b);
	localparam logic [7:0]    TEMP_VALUE   = 8'd25;
	localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(1000);

	typedef enum logic [2:0] {
		FUNC_WR_START = 3'd0,
		FUNC_WR_BYTE  = 3'd1,
		FUNC_RD_BYTE  = 3'd2,
		FUNC_ENABLE   = 3'd3,
		FUNC_TICK     = 3'd4
	} func_t;

	// One bus event, already qualified by the pipeline advance.
	typedef struct packed {
		logic       wr_start;
		logic       wr_byte;
		logic       rd_byte;
		logic [7:0] data;
	} bus_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/pmicrs_regbank.sv
// Register file, register pointer and pointer capture of the bus slave.
// Depends on pmicrs_pkg.
`default_nettype none

module pmicrs_regbank
	import pmicrs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire bus_cmd_t cmd,
	output logic [7:0]    rd_data
);

	logic [7:0] regs_q [REG_COUNT];
	logic [7:0] ptr_q;
	logic       await_q;
	logic       in_range;
	reg_idx_t   idx;

	assign in_range = (ptr_q < 8'(REG_COUNT));
	assign idx      = ptr_q[REG_IDX_W-1:0];
	assign rd_data  = (cmd.rd_byte && in_range) ? regs_q[idx] : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= 8'd0;
			await_q <= 1'b1;
		end else if (cmd.wr_start) begin
			await_q <= 1'b1;
		end else if (cmd.wr_byte) begin
			if (await_q) begin
				ptr_q   <= cmd.data;
				await_q <= 1'b0;
			end else if (in_range) begin
				ptr_q <= ptr_q + 8'd1;
			end
		end else if (cmd.rd_byte && in_range) begin
			ptr_q <= ptr_q + 8'd1;
		end
	end

	// The temperature entry holds its reset value forever; fault entries only clear bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				regs_q[i] <= (reg_idx_t'(i) == TEMP_REG) ? TEMP_VALUE : 8'd0;
			end
		end else if (cmd.wr_byte && !await_q && in_range) begin
			if (idx == FAULT_REG_A || idx == FAULT_REG_B) begin
				regs_q[idx] <= regs_q[idx] & cmd.data;
			end else if (idx != TEMP_REG) begin
				regs_q[idx] <= cmd.data;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/pmic_register_slave_with_settle_top.sv
// Each beat on the input stream is one event: a bus write start, a written byte, a read
// byte, an enable level change or a time tick, and it yields exactly one output beat with
// the read byte (zero unless the event is a read) and the power-good level after the
// event. A beat is registered, then worked between that input register and the output
// register, so the block takes one beat per cycle; only back-pressure on the output
// stream slows it. Power-good asserts settle_ticks ticks after enable rises and drops
// on the beat that lowers enable. The user must write settle_ticks only while no beat
// is in flight; the block itself does not enforce it.
`default_nettype none

module pmic_register_slave_with_settle_top
	import pmicrs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                settle_ticks_we,
	input  wire logic [SETTLE_W-1:0] settle_ticks_wdata,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [15:0]         s_tdata,   // [7:0] data, [8] level, [15:9] zero
	input  wire logic [2:0]          s_tuser,   // [2:0] func
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [15:0]              m_tdata    // [7:0] read_data, [8] pgood, [15:9] zero
);

	logic [SETTLE_W-1:0] settle_ticks_q;
	logic                valid_s1;
	logic [2:0]          func_s1;
	logic [7:0]          data_s1;
	logic                level_s1;
	logic                adv;
	logic                s_accept;

	logic                en_level_q, en_level_d;
	logic                pending_q, pending_d;
	logic [SETTLE_W-1:0] cnt_q, cnt_d;
	logic                pgood_q, pgood_d;

	logic                out_valid_q;
	logic [7:0]          out_rd_q;
	logic                out_pg_q;

	bus_cmd_t            cmd;
	logic [7:0]          rd_data;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_ticks_q <= SETTLE_RESET;
		end else if (settle_ticks_we) begin
			settle_ticks_q <= settle_ticks_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			func_s1  <= s_tuser;
			data_s1  <= s_tdata[7:0];
			level_s1 <= s_tdata[8];
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.data     = data_s1;
		en_level_d   = en_level_q;
		pending_d    = pending_q;
		cnt_d        = cnt_q;
		pgood_d      = pgood_q;
		unique case (func_s1)
			FUNC_WR_START: cmd.wr_start = adv;
			FUNC_WR_BYTE:  cmd.wr_byte  = adv;
			FUNC_RD_BYTE:  cmd.rd_byte  = adv;
			FUNC_ENABLE: begin
				en_level_d = level_s1;
				if (level_s1) begin
					pending_d = 1'b1;
					cnt_d     = settle_ticks_q;
				end else begin
					pending_d = 1'b0;
					cnt_d     = '0;
					pgood_d   = 1'b0;
				end
			end
			FUNC_TICK: begin
				// A count of zero or one ends the settle on this tick.
				if (pending_q) begin
					if (cnt_q <= SETTLE_W'(1)) begin
						cnt_d     = '0;
						pending_d = 1'b0;
						pgood_d   = en_level_q;
					end else begin
						cnt_d = cnt_q - SETTLE_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	pmicrs_regbank u_regbank (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_level_q <= 1'b0;
			pending_q  <= 1'b0;
			cnt_q      <= '0;
			pgood_q    <= 1'b0;
		end else if (adv) begin
			en_level_q <= en_level_d;
			pending_q  <= pending_d;
			cnt_q      <= cnt_d;
			pgood_q    <= pgood_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_rd_q <= rd_data;
			out_pg_q <= pgood_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_pg_q, out_rd_q};

	// Power-good can only be high while enable is high.
	a_pgood_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		pgood_q |-> en_level_q)
		else $error("power-good high with enable low");

	// An idle settle counter is always parked at zero.
	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!pending_q |-> (cnt_q == '0))
		else $error("settle count nonzero with no settle pending");

	// A beat in the input stage holds while the output is blocked.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |=> (valid_s1 && $stable(func_s1)))
		else $error("input stage changed while output stalled");

endmodule

`default_nettype wire
